FILE: rtl/bbr_pkg.sv
// Package for the 3x3 RGB box blur: widths, register indexes, lane and result control types.
// Also holds the reciprocal table used for the truncating division by the window size.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bbr_pkg;

	localparam int CH_W       = 8;
	localparam int PIX_W      = 3 * CH_W;
	localparam int DIM_W      = 13;
	localparam int ROW_W      = 12;
	localparam int MAX_HEIGHT = 4096;
	localparam int WIN_N      = 9;
	localparam int SUM_W      = 12;
	localparam int CNT_W      = 4;
	localparam int RECIP_W    = 17;
	localparam int RECIP_SH   = 16;

	localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic             load;
		logic [WIN_N-1:0] mask;
		logic [CNT_W-1:0] count;
	} lane_ctl_t;

	typedef struct packed {
		logic valid;
		logic run_last;
		logic frame_last;
	} res_ctl_t;

	// Multiplier that turns sum * m >> 16 into sum / count for every sum a clipped window yields.
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
		logic [RECIP_W-1:0] m;
		case (count)
			4'd2:    m = 17'd32768;
			4'd3:    m = 17'd21846;
			4'd4:    m = 17'd16384;
			4'd6:    m = 17'd10923;
			4'd9:    m = 17'd7282;
			default: m = 17'd65536;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/bbr_pix_if.sv
// Pixel input channel of the box blur: valid/ready handshake and one RGB pixel.
// Depends on bbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bbr_pix_if;
	logic                     valid;
	logic                     ready;
	logic [bbr_pkg::CH_W-1:0] red_in;
	logic [bbr_pkg::CH_W-1:0] green_in;
	logic [bbr_pkg::CH_W-1:0] blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in, input ready);
	modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

`default_nettype wire

FILE: rtl/bbr_res_if.sv
// Result channel of the box blur: valid/ready handshake, blurred RGB pixel and end markers.
// Depends on bbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bbr_res_if;
	logic                     valid;
	logic                     ready;
	logic [bbr_pkg::CH_W-1:0] red_out;
	logic [bbr_pkg::CH_W-1:0] green_out;
	logic [bbr_pkg::CH_W-1:0] blue_out;
	logic                     run_last;
	logic                     frame_last;

	modport source (output valid, output red_out, output green_out, output blue_out,
		output run_last, output frame_last, input ready);
	modport sink   (input valid, input red_out, input green_out, input blue_out,
		input run_last, input frame_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/box_blur_3x3_rgb_top.sv
// Each pixel passes through stage 1, the window stage, the stage-3 lane registers and the result
// register. Throughput: one pixel per cycle while each pixel yields at most one result and the
// result channel does not stall; a pixel with up to four results (last row and column) holds the
// window stage until its last result moves on. Reset clears all control state, sets the frame to
// 640 x 480; the line buffers are not cleared, since clipped windows never read an unwritten entry.
`timescale 1ns / 1ps
`default_nettype none

module box_blur_3x3_rgb_top #(
	parameter int MAX_WIDTH = 4096
) (
	input  wire                         clk,
	input  wire                         arst_n,
	bbr_pix_if.sink                     pixel,
	bbr_res_if.source                   result,
	input  wire                         cfg_we,
	input  bbr_pkg::cfg_idx_t           cfg_index,
	input  wire [bbr_pkg::DIM_W-1:0]    cfg_data
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int CMW = bbr_pkg::DIM_W + 1;
	localparam int PW  = bbr_pkg::PIX_W;

	typedef struct packed {
		logic r_ge1;
		logic r_ge2;
		logic c_ge1;
		logic c_ge2;
		logic lrow;
		logic lcol;
	} pos_flags_t;

	logic [bbr_pkg::DIM_W-1:0] width_q;
	logic [bbr_pkg::DIM_W-1:0] height_q;
	logic [CW-1:0]             w_last;
	logic [bbr_pkg::ROW_W-1:0] h_last;
	logic [CW-1:0]             c_q;
	logic [bbr_pkg::ROW_W-1:0] r_q;

	logic          accept;
	logic          transfer;
	logic          s1_v_q;
	logic [PW-1:0] pix_s1;
	logic [CW-1:0] col_s1;
	pos_flags_t    flags_s1;
	logic          hit_s1;
	logic [PW-1:0] byp_old_q;
	logic [PW-1:0] byp_new_q;
	logic [PW-1:0] ram_old;
	logic [PW-1:0] ram_new;
	logic [PW-1:0] old_px;
	logic [PW-1:0] new_px;

	logic [2:0][2:0][PW-1:0] win_q;

	logic       job_v_q;
	logic       rcur_q;
	logic       ccur_q;
	pos_flags_t job_f_q;
	logic       has_res;
	logic       last_res;
	logic       emit;
	logic       job_done;
	logic [2:0] rowm;
	logic [2:0] colm;
	logic [bbr_pkg::WIN_N-1:0] mask;

	logic                adv3;
	logic                adv4;
	bbr_pkg::res_ctl_t   res_s3;
	bbr_pkg::lane_ctl_t  lane_ctl;
	logic [2:0][bbr_pkg::WIN_N-1:0][bbr_pkg::CH_W-1:0] lane_px;
	logic [2:0][bbr_pkg::CH_W-1:0]                     lane_mean;

	// Configuration registers and the clamped frame size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bbr_pkg::WIDTH_RST;
			height_q <= bbr_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bbr_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				bbr_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			w_last = '0;
		end else if (CMW'(width_q) > CMW'(MAX_WIDTH)) begin
			w_last = CW'(MAX_WIDTH - 1);
		end else begin
			w_last = CW'(width_q - 1'b1);
		end
		if (height_q == '0) begin
			h_last = '0;
		end else if (height_q > bbr_pkg::DIM_W'(bbr_pkg::MAX_HEIGHT)) begin
			h_last = bbr_pkg::ROW_W'(bbr_pkg::MAX_HEIGHT - 1);
		end else begin
			h_last = bbr_pkg::ROW_W'(height_q - 1'b1);
		end
	end

	// Position of the next input pixel.
	assign pixel.ready = !s1_v_q || transfer;
	assign accept      = pixel.valid && pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			r_q <= '0;
		end else if (cfg_we) begin
			c_q <= '0;
			r_q <= '0;
		end else if (accept) begin
			if (c_q == w_last) begin
				c_q <= '0;
				r_q <= (r_q == h_last) ? '0 : r_q + 1'b1;
			end else begin
				c_q <= c_q + 1'b1;
			end
		end
	end

	// Stage 1: the pixel waits here while the line buffers are read at its column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (accept) begin
			s1_v_q <= 1'b1;
		end else if (transfer) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1         <= {pixel.red_in, pixel.green_in, pixel.blue_in};
			col_s1         <= c_q;
			hit_s1         <= transfer && (col_s1 == c_q);
			flags_s1.r_ge1 <= (r_q != '0);
			flags_s1.r_ge2 <= (r_q > bbr_pkg::ROW_W'(1));
			flags_s1.c_ge1 <= (c_q != '0);
			flags_s1.c_ge2 <= (c_q > CW'(1));
			flags_s1.lrow  <= (r_q == h_last);
			flags_s1.lcol  <= (c_q == w_last);
		end
		if (transfer) begin
			byp_old_q <= new_px;
			byp_new_q <= pix_s1;
		end
	end

	// A read issued in the same cycle as the write to that column returns the older entry.
	assign old_px = hit_s1 ? byp_old_q : ram_old;
	assign new_px = hit_s1 ? byp_new_q : ram_new;

	bbr_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_older_row (
		.clk   (clk),
		.we    (transfer),
		.waddr (col_s1),
		.wdata (new_px),
		.re    (accept),
		.raddr (c_q),
		.rdata (ram_old)
	);

	bbr_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_newer_row (
		.clk   (clk),
		.we    (transfer),
		.waddr (col_s1),
		.wdata (pix_s1),
		.re    (accept),
		.raddr (c_q),
		.rdata (ram_new)
	);

	// Stage 2: the window, and the walk over the results that one pixel produces.
	assign transfer = s1_v_q && (!job_v_q || job_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (transfer) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= old_px;
			win_q[1][2] <= new_px;
			win_q[2][2] <= pix_s1;
		end
	end

	assign has_res  = (job_f_q.r_ge1 || job_f_q.lrow) && (job_f_q.c_ge1 || job_f_q.lcol);
	assign last_res = !(!ccur_q && job_f_q.lcol) && !(!rcur_q && job_f_q.lrow);
	assign emit     = job_v_q && has_res;
	assign job_done = job_v_q && (!has_res || (adv3 && last_res));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_q <= 1'b0;
			rcur_q  <= 1'b0;
			ccur_q  <= 1'b0;
			job_f_q <= '0;
		end else if (transfer) begin
			job_v_q <= 1'b1;
			rcur_q  <= !flags_s1.r_ge1;
			ccur_q  <= !flags_s1.c_ge1;
			job_f_q <= flags_s1;
		end else if (job_done) begin
			job_v_q <= 1'b0;
		end else if (emit && adv3) begin
			if (!ccur_q && job_f_q.lcol) begin
				ccur_q <= 1'b1;
			end else begin
				rcur_q <= 1'b1;
				ccur_q <= !job_f_q.c_ge1;
			end
		end
	end

	// Clipping: rows and columns of the window that lie inside the frame for this result.
	always_comb begin
		rowm = rcur_q ? {1'b1, job_f_q.r_ge1, 1'b0} : {1'b1, 1'b1, job_f_q.r_ge2};
		colm = ccur_q ? {1'b1, job_f_q.c_ge1, 1'b0} : {1'b1, 1'b1, job_f_q.c_ge2};
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				mask[i * 3 + j] = rowm[i] && colm[j];
			end
		end
	end

	assign lane_ctl.load  = emit && adv3;
	assign lane_ctl.mask  = mask;
	assign lane_ctl.count = bbr_pkg::CNT_W'($countones(mask));

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					lane_px[ch][i * 3 + j] =
						win_q[i][j][(2 - ch) * bbr_pkg::CH_W +: bbr_pkg::CH_W];
				end
			end
		end
	end

	// Stage 3: the three colour lanes hold their sums; their control travels alongside.
	assign adv3 = !res_s3.valid || adv4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s3 <= '0;
		end else if (adv3) begin
			res_s3.valid      <= emit;
			res_s3.run_last   <= last_res;
			res_s3.frame_last <= rcur_q && ccur_q;
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		bbr_lane u_lane (
			.clk  (clk),
			.ctl  (lane_ctl),
			.px   (lane_px[ch]),
			.mean (lane_mean[ch])
		);
	end

	bbr_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (res_s3),
		.red     (lane_mean[0]),
		.green   (lane_mean[1]),
		.blue    (lane_mean[2]),
		.load_ok (adv4),
		.res     (result)
	);

	// The input position always lies inside the clamped frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		(c_q <= w_last) && (r_q <= h_last))
		else $error("input position outside the frame");

	// A register write restarts the frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (c_q == '0) && (r_q == '0))
		else $error("frame not restarted after a register write");

	// The result being produced refers to a row and a column that the pixel really yields.
	assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> ((rcur_q ? job_f_q.lrow : job_f_q.r_ge1) &&
			(ccur_q ? job_f_q.lcol : job_f_q.c_ge1)))
		else $error("result walk left the valid rows or columns");

	// The bottom-right result is always the last one of its pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_s3.valid && res_s3.frame_last) |-> res_s3.run_last)
		else $error("frame end marked on a result that is not the last of its pixel");

endmodule

`default_nettype wire

FILE: rtl/bbr_ram.sv
// Generic single-write, single-read RAM with a registered read port and read enable.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bbr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bbr_lane.sv
// One colour lane of the box blur: masked sum over the 3x3 window, registered, then a
// truncating division by the window size through a reciprocal multiply. Depends on bbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbr_lane (
	input  wire                                          clk,
	input  bbr_pkg::lane_ctl_t                           ctl,
	input  wire [bbr_pkg::WIN_N-1:0][bbr_pkg::CH_W-1:0]  px,
	output logic [bbr_pkg::CH_W-1:0]                     mean
);

	localparam int PROD_W = bbr_pkg::SUM_W + bbr_pkg::RECIP_W;

	logic [bbr_pkg::SUM_W-1:0] sum;
	logic [bbr_pkg::SUM_W-1:0] sum_s3;
	logic [bbr_pkg::CNT_W-1:0] count_s3;
	logic [PROD_W-1:0]         prod;

	always_comb begin
		sum = '0;
		for (int i = 0; i < bbr_pkg::WIN_N; i++) begin
			if (ctl.mask[i]) begin
				sum = sum + bbr_pkg::SUM_W'(px[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sum_s3   <= sum;
			count_s3 <= ctl.count;
		end
	end

	assign prod = PROD_W'(sum_s3) * PROD_W'(bbr_pkg::recip(count_s3));
	assign mean = prod[bbr_pkg::RECIP_SH +: bbr_pkg::CH_W];

endmodule

`default_nettype wire

FILE: rtl/bbr_merge.sv
// Output stage of the box blur: gathers the three lane means and the end markers into the
// result register that drives the result channel. Depends on bbr_pkg and bbr_res_if.
`timescale 1ns / 1ps
`default_nettype none

module bbr_merge (
	input  wire                       clk,
	input  wire                       arst_n,
	input  bbr_pkg::res_ctl_t         ctl,
	input  wire [bbr_pkg::CH_W-1:0]   red,
	input  wire [bbr_pkg::CH_W-1:0]   green,
	input  wire [bbr_pkg::CH_W-1:0]   blue,
	output logic                      load_ok,
	bbr_res_if.source                 res
);

	logic                     valid_q;
	logic [bbr_pkg::CH_W-1:0] red_q;
	logic [bbr_pkg::CH_W-1:0] green_q;
	logic [bbr_pkg::CH_W-1:0] blue_q;
	logic                     run_last_q;
	logic                     frame_last_q;

	assign load_ok = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ok) begin
			valid_q <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok && ctl.valid) begin
			red_q        <= red;
			green_q      <= green;
			blue_q       <= blue;
			run_last_q   <= ctl.run_last;
			frame_last_q <= ctl.frame_last;
		end
	end

	assign res.valid      = valid_q;
	assign res.red_out    = red_q;
	assign res.green_out  = green_q;
	assign res.blue_out   = blue_q;
	assign res.run_last   = run_last_q;
	assign res.frame_last = frame_last_q;

endmodule

`default_nettype wire
